>>> hw/rtl/rcca_pkg.sv
package rcca_pkg;

    localparam int unsigned NUM_CHANNELS_DEF = 32;
    localparam int unsigned NUM_CHUNKS_DEF   = 32;

    // Width of the channel, chunk and slot fields.
    localparam int unsigned IDX_W = 5;
    // Width of a usage count.
    localparam int unsigned CNT_W = 8;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [3:0] {
        OP_ALLOC_CH = 4'd0,
        OP_INC_CH   = 4'd1,
        OP_DEC_CH   = 4'd2,
        OP_SET_CH   = 4'd3,
        OP_READ_CH  = 4'd4,
        OP_ALLOC_CK = 4'd5,
        OP_INC_CK   = 4'd6,
        OP_DEC_CK   = 4'd7,
        OP_READ_CK  = 4'd8,
        OP_SET_EOS  = 4'd9,
        OP_READ_EOS = 4'd10
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EXHAUSTED = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_SATURATED = 2'd3
    } status_t;

    typedef struct packed {
        logic             eos_in;
        logic [CNT_W-1:0] new_count;
        logic [IDX_W-1:0] chunk;
        logic [IDX_W-1:0] channel;
        op_t              op;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic             freed;
        logic             eos_out;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] slot;
    } res_t;

endpackage

>>> hw/rtl/rcca_engine.sv
module rcca_engine #(
    parameter int unsigned NUM_CHANNELS = rcca_pkg::NUM_CHANNELS_DEF,
    parameter int unsigned NUM_CHUNKS   = rcca_pkg::NUM_CHUNKS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  rcca_pkg::req_t  in_req,
    output logic            res_valid,
    input  logic            res_ready,
    output rcca_pkg::res_t  res
);

    // Only the slots that the 5-bit fields can address are stored.
    localparam int unsigned CH_ADDR  = (NUM_CHANNELS < 32) ? NUM_CHANNELS : 32;
    localparam int unsigned CK_ADDR  = (NUM_CHUNKS < 32) ? NUM_CHUNKS : 32;
    localparam int unsigned CK_DEPTH = CH_ADDR * CK_ADDR;
    localparam int unsigned CH_IW    = (CH_ADDR > 1) ? $clog2(CH_ADDR) : 1;
    localparam int unsigned CK_AW    = (CK_DEPTH > 1) ? $clog2(CK_DEPTH) : 1;

    localparam logic [rcca_pkg::IDX_W-1:0] CH_LAST = rcca_pkg::IDX_W'(CH_ADDR - 1);
    localparam logic [rcca_pkg::IDX_W-1:0] CK_LAST = rcca_pkg::IDX_W'(CK_ADDR - 1);
    localparam logic [CK_AW-1:0]           CLR_LAST = CK_AW'(CK_DEPTH - 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_READ  = 6'b001000,
        S_SWEEP = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    typedef struct packed {
        logic                       eos;
        logic [rcca_pkg::CNT_W-1:0] count;
    } ck_word_t;

    function automatic logic [CK_AW-1:0] ck_addr(
        input logic [rcca_pkg::IDX_W-1:0] ch,
        input logic [rcca_pkg::IDX_W-1:0] ck
    );
        return CK_AW'(32'(ch) * CK_ADDR + 32'(ck));
    endfunction

    logic [rcca_pkg::CNT_W-1:0] ch_mem [CH_ADDR];
    ck_word_t                   ck_mem [CK_DEPTH];

    logic [rcca_pkg::CNT_W-1:0] ch_rd_reg;
    ck_word_t                   ck_rd_reg;

    logic                       ch_we;
    logic [CH_IW-1:0]           ch_wa;
    logic [rcca_pkg::CNT_W-1:0] ch_wd;
    logic [CH_IW-1:0]           ch_ra;
    logic                       ck_we;
    logic [CK_AW-1:0]           ck_wa;
    ck_word_t                   ck_wd;
    logic [CK_AW-1:0]           ck_ra;

    state_t                     state_reg, state_next;
    rcca_pkg::req_t             req_reg, req_next;
    rcca_pkg::res_t             res_reg, res_next;
    logic [rcca_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [CK_AW-1:0]           clr_reg, clr_next;

    logic                       ch_ok;
    logic                       ck_ok;
    logic                       is_ch_scan;
    logic                       at_end;
    logic [rcca_pkg::IDX_W-1:0] idx_adv;
    logic                       hit;
    logic                       is_ch_op;
    logic [rcca_pkg::CNT_W-1:0] cur_cnt;
    logic [rcca_pkg::CNT_W-1:0] new_cnt;
    logic                       new_eos;
    logic                       freed;
    rcca_pkg::status_t          stat;

    always_ff @(posedge aclk) begin
        if (ch_we) begin
            ch_mem[ch_wa] <= ch_wd;
        end
        ch_rd_reg <= ch_mem[ch_ra];
    end

    always_ff @(posedge aclk) begin
        if (ck_we) begin
            ck_mem[ck_wa] <= ck_wd;
        end
        ck_rd_reg <= ck_mem[ck_ra];
    end

    assign ch_ok = 32'(in_req.channel) < CH_ADDR;
    assign ck_ok = ch_ok && (32'(in_req.chunk) < CK_ADDR);

    // The scan and the release sweep share one index: it names the entry whose
    // read data arrives this cycle, while the read of the next entry is issued.
    assign is_ch_scan = (req_reg.op == rcca_pkg::OP_ALLOC_CH);
    assign at_end     = (state_reg == S_SCAN && is_ch_scan) ? (idx_reg == CH_LAST)
                                                           : (idx_reg == CK_LAST);
    assign idx_adv    = at_end ? idx_reg : idx_reg + 1'b1;
    assign hit        = is_ch_scan ? (ch_rd_reg == '0) : (ck_rd_reg.count == '0);

    assign is_ch_op = (req_reg.op inside {rcca_pkg::OP_INC_CH, rcca_pkg::OP_DEC_CH,
                                         rcca_pkg::OP_SET_CH, rcca_pkg::OP_READ_CH});
    assign cur_cnt  = is_ch_op ? ch_rd_reg : ck_rd_reg.count;

    always_comb begin
        new_cnt = cur_cnt;
        new_eos = ck_rd_reg.eos;
        freed   = 1'b0;
        stat    = rcca_pkg::STAT_OK;
        case (req_reg.op)
            rcca_pkg::OP_INC_CH, rcca_pkg::OP_INC_CK: begin
                if (cur_cnt == rcca_pkg::COUNT_MAX) begin
                    stat = rcca_pkg::STAT_SATURATED;
                end else begin
                    new_cnt = cur_cnt + 1'b1;
                end
            end
            rcca_pkg::OP_DEC_CH, rcca_pkg::OP_DEC_CK: begin
                if (cur_cnt == '0) begin
                    stat = rcca_pkg::STAT_UNDERFLOW;
                end else begin
                    new_cnt = cur_cnt - 1'b1;
                    freed   = (new_cnt == '0);
                end
            end
            rcca_pkg::OP_SET_CH: begin
                new_cnt = req_reg.new_count;
            end
            rcca_pkg::OP_SET_EOS: begin
                new_eos = req_reg.eos_in;
            end
            default: begin
            end
        endcase
        // A chunk that a decrement releases loses its end-of-stream mark.
        if (req_reg.op == rcca_pkg::OP_DEC_CK && freed) begin
            new_eos = 1'b0;
        end
    end

    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        res_next   = res_reg;
        idx_next   = idx_reg;
        clr_next   = clr_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        ch_we      = 1'b0;
        ch_wa      = req_reg.channel[CH_IW-1:0];
        ch_wd      = '0;
        ch_ra      = req_reg.channel[CH_IW-1:0];
        ck_we      = 1'b0;
        ck_wa      = ck_addr(req_reg.channel, req_reg.chunk);
        ck_wd      = '0;
        ck_ra      = ck_addr(req_reg.channel, req_reg.chunk);

        unique case (state_reg)
            S_CLEAR: begin
                ch_we = (32'(clr_reg) < CH_ADDR);
                ch_wa = clr_reg[CH_IW-1:0];
                ck_we = 1'b1;
                ck_wa = clr_reg;
                if (clr_reg == CLR_LAST) begin
                    state_next = S_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                ch_ra    = in_req.channel[CH_IW-1:0];
                ck_ra    = ck_addr(in_req.channel, in_req.chunk);
                if (in_req.op == rcca_pkg::OP_ALLOC_CH) begin
                    ch_ra = '0;
                end
                if (in_req.op == rcca_pkg::OP_ALLOC_CK) begin
                    ck_ra = ck_addr(in_req.channel, '0);
                end
                if (in_valid) begin
                    req_next = in_req;
                    res_next = '0;
                    idx_next = '0;
                    unique case (in_req.op) inside
                        rcca_pkg::OP_ALLOC_CH: begin
                            state_next = S_SCAN;
                        end
                        rcca_pkg::OP_INC_CH, rcca_pkg::OP_DEC_CH,
                        rcca_pkg::OP_SET_CH, rcca_pkg::OP_READ_CH: begin
                            state_next = ch_ok ? S_READ : S_DONE;
                        end
                        rcca_pkg::OP_ALLOC_CK: begin
                            if (ch_ok) begin
                                state_next = S_SCAN;
                            end else begin
                                res_next.status = rcca_pkg::STAT_EXHAUSTED;
                                state_next      = S_DONE;
                            end
                        end
                        rcca_pkg::OP_INC_CK, rcca_pkg::OP_DEC_CK, rcca_pkg::OP_READ_CK,
                        rcca_pkg::OP_SET_EOS, rcca_pkg::OP_READ_EOS: begin
                            state_next = ck_ok ? S_READ : S_DONE;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                ch_ra = idx_adv[CH_IW-1:0];
                ck_ra = ck_addr(req_reg.channel, idx_adv);
                if (hit) begin
                    if (is_ch_scan) begin
                        ch_we = 1'b1;
                        ch_wa = idx_reg[CH_IW-1:0];
                        ch_wd = rcca_pkg::CNT_W'(1);
                    end else begin
                        ck_we       = 1'b1;
                        ck_wa       = ck_addr(req_reg.channel, idx_reg);
                        ck_wd.eos   = 1'b0;
                        ck_wd.count = rcca_pkg::CNT_W'(1);
                    end
                    res_next.slot  = idx_reg;
                    res_next.count = rcca_pkg::CNT_W'(1);
                    state_next     = S_DONE;
                end else if (at_end) begin
                    res_next.status = rcca_pkg::STAT_EXHAUSTED;
                    state_next      = S_DONE;
                end else begin
                    idx_next = idx_adv;
                end
            end
            S_READ: begin
                if (is_ch_op) begin
                    ch_we = 1'b1;
                    ch_wd = new_cnt;
                end else begin
                    ck_we       = 1'b1;
                    ck_wd.eos   = new_eos;
                    ck_wd.count = new_cnt;
                end
                res_next.count   = new_cnt;
                res_next.eos_out = is_ch_op ? 1'b0 : new_eos;
                res_next.freed   = freed;
                res_next.status  = stat;
                if (req_reg.op == rcca_pkg::OP_DEC_CH && freed) begin
                    // Release of a channel: clear every chunk count of its row.
                    ck_ra      = ck_addr(req_reg.channel, '0);
                    idx_next   = '0;
                    state_next = S_SWEEP;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_SWEEP: begin
                ck_ra       = ck_addr(req_reg.channel, idx_adv);
                ck_we       = 1'b1;
                ck_wa       = ck_addr(req_reg.channel, idx_reg);
                ck_wd.eos   = ck_rd_reg.eos;
                ck_wd.count = '0;
                if (at_end) begin
                    state_next = S_DONE;
                end else begin
                    idx_next = idx_adv;
                end
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
        res_reg <= res_next;
        idx_reg <= idx_next;
    end

    assign res = res_reg;

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> !in_ready)
        else $error("a second item was taken before the first one finished");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN && is_ch_scan |-> 32'(idx_reg) < CH_ADDR)
        else $error("channel scan ran past the last channel");

    a_exhausted_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.status == rcca_pkg::STAT_EXHAUSTED |->
            res.slot == '0 && res.count == '0 && !res.eos_out)
        else $error("exhausted result carries nonzero fields");

    a_freed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.freed |-> res.count == '0 && res.status == rcca_pkg::STAT_OK)
        else $error("released slot reports a nonzero count");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed before it was taken");

endmodule

>>> hw/rtl/refcounted_channel_chunk_allocator.sv
// Two-level pool of reference-counted slots: up to 32 channels with up to 32 chunks each,
// every slot with an 8-bit usage count and every chunk with an end-of-stream flag. Each
// request on the slave stream gives exactly one result on the master stream. After reset
// the block clears its memories one entry per cycle, min(NUM_CHANNELS,32) *
// min(NUM_CHUNKS,32) entries (1024 by default), with s_tready low. Requests are handled
// one at a time. For count and flag accesses the memory read is issued while the request
// waits at the input, then the engine does one read-modify-write and one handoff. An
// allocation scans the channel or chunk memory one entry per cycle, granting the first
// free slot or reporting an exhausted pool. A channel decrement that releases the channel
// then sweeps the chunk row one entry per cycle. Out-of-range requests and unused op codes
// go straight to the result without a memory access. Each memory has a single read and
// write port. A finished result waits in the output register without holding up the next
// request.
module refcounted_channel_chunk_allocator #(
    parameter int unsigned NUM_CHANNELS = rcca_pkg::NUM_CHANNELS_DEF,
    parameter int unsigned NUM_CHUNKS   = rcca_pkg::NUM_CHUNKS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[3:0], channel[8:4], chunk[13:9], new_count[21:14], eos_in[22], zero[23]
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // slot[4:0], count[12:5], eos_out[13], freed[14], status[16:15], zero[23:17]
    output logic [23:0] m_tdata
);

    rcca_pkg::req_t in_req;
    rcca_pkg::res_t res;
    logic           res_valid;
    logic           res_ready;
    logic           m_tvalid_reg;
    logic [23:0]    m_tdata_reg;

    assign in_req.op        = rcca_pkg::op_t'(s_tdata[3:0]);
    assign in_req.channel   = s_tdata[8:4];
    assign in_req.chunk     = s_tdata[13:9];
    assign in_req.new_count = s_tdata[21:14];
    assign in_req.eos_in    = s_tdata[22];

    rcca_engine #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .NUM_CHUNKS   (NUM_CHUNKS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (in_req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // The output register takes a new result whenever it is empty or being drained.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= {7'd0, res.status, res.freed, res.eos_out, res.count, res.slot};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> tb/sv/tb.sv
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CH_N      = rcca_pkg::NUM_CHANNELS_DEF;
    localparam int CK_N      = rcca_pkg::NUM_CHUNKS_DEF;
    localparam int CH_SCAN   = (CH_N < 32) ? CH_N : 32;
    localparam int CK_SCAN   = (CK_N < 32) ? CK_N : 32;
    // Longest quiet stretch: the clearing pass after reset dominates.
    localparam int STALL_LIMIT  = 8000;
    localparam int RANDOM_ITEMS = 1540;
    // Op codes that the block does not define.
    localparam logic [3:0] OP_UNUSED_FIRST = 4'd11;
    localparam logic [3:0] OP_UNUSED_LAST  = 4'd15;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // op[3:0], channel[8:4], chunk[13:9], new_count[21:14], eos_in[22], zero[23]
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // slot[4:0], count[12:5], eos_out[13], freed[14], status[16:15], zero[23:17]
    logic [23:0] m_tdata;

    refcounted_channel_chunk_allocator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #2 aclk = ~aclk;

    // Shadow copy of the pool state.
    logic [rcca_pkg::CNT_W-1:0] channel_use [CH_N];
    logic [rcca_pkg::CNT_W-1:0] chunk_use   [CH_N][CK_N];
    logic                       eos_flag    [CH_N][CK_N];

    rcca_pkg::res_t pending_results[$];
    int   error_count = 0;
    int   quiet_cycles = 0;

    int   src_stretch = 0;
    bit   src_calm = 1'b0;
    int   snk_stretch = 0;
    bit   snk_calm = 1'b0;

    // Gaps come in stretches, some of which have no idling at all.
    function automatic int draw_wait(ref int stretch, ref bit calm);
        if (stretch == 0) begin
            stretch = $urandom_range(5, 40);
            calm = ($urandom_range(0, 3) == 0);
        end
        stretch--;
        return calm ? 0 : $urandom_range(0, 3);
    endfunction

    function automatic rcca_pkg::req_t make_req(rcca_pkg::op_t op, int ch, int ck, int nc,
                                                bit e);
        rcca_pkg::req_t r;
        r.op = op;
        r.channel = rcca_pkg::IDX_W'(ch);
        r.chunk = rcca_pkg::IDX_W'(ck);
        r.new_count = rcca_pkg::CNT_W'(nc);
        r.eos_in = e;
        return r;
    endfunction

    function automatic rcca_pkg::res_t predict_pool_result(rcca_pkg::req_t r);
        rcca_pkg::res_t e;
        bit ch_ok;
        bit ck_ok;
        bit found;
        e = '0;
        e.status = rcca_pkg::STAT_OK;
        found = 1'b0;
        ch_ok = (int'(r.channel) < CH_N);
        ck_ok = ch_ok && (int'(r.chunk) < CK_N);
        case (r.op)
            rcca_pkg::OP_ALLOC_CH: begin
                for (int i = 0; i < CH_SCAN; i++) begin
                    if (!found && channel_use[i] == '0) begin
                        channel_use[i] = rcca_pkg::CNT_W'(1);
                        e.slot = rcca_pkg::IDX_W'(i);
                        e.count = rcca_pkg::CNT_W'(1);
                        found = 1'b1;
                    end
                end
                if (!found)
                    e.status = rcca_pkg::STAT_EXHAUSTED;
            end
            rcca_pkg::OP_INC_CH, rcca_pkg::OP_DEC_CH, rcca_pkg::OP_SET_CH,
            rcca_pkg::OP_READ_CH: begin
                if (ch_ok) begin
                    if (r.op == rcca_pkg::OP_INC_CH) begin
                        if (channel_use[r.channel] == rcca_pkg::COUNT_MAX)
                            e.status = rcca_pkg::STAT_SATURATED;
                        else
                            channel_use[r.channel]++;
                    end else if (r.op == rcca_pkg::OP_DEC_CH) begin
                        if (channel_use[r.channel] == '0) begin
                            e.status = rcca_pkg::STAT_UNDERFLOW;
                        end else begin
                            channel_use[r.channel]--;
                            // Releasing a channel drops every chunk count but keeps the flags.
                            if (channel_use[r.channel] == '0) begin
                                e.freed = 1'b1;
                                for (int j = 0; j < CK_N; j++)
                                    chunk_use[r.channel][j] = '0;
                            end
                        end
                    end else if (r.op == rcca_pkg::OP_SET_CH) begin
                        channel_use[r.channel] = r.new_count;
                    end
                    e.count = channel_use[r.channel];
                end
            end
            rcca_pkg::OP_ALLOC_CK: begin
                if (ch_ok) begin
                    for (int i = 0; i < CK_SCAN; i++) begin
                        if (!found && chunk_use[r.channel][i] == '0) begin
                            chunk_use[r.channel][i] = rcca_pkg::CNT_W'(1);
                            eos_flag[r.channel][i] = 1'b0;
                            e.slot = rcca_pkg::IDX_W'(i);
                            e.count = rcca_pkg::CNT_W'(1);
                            found = 1'b1;
                        end
                    end
                end
                if (!found)
                    e.status = rcca_pkg::STAT_EXHAUSTED;
            end
            rcca_pkg::OP_INC_CK, rcca_pkg::OP_DEC_CK, rcca_pkg::OP_READ_CK,
            rcca_pkg::OP_SET_EOS, rcca_pkg::OP_READ_EOS: begin
                if (ck_ok) begin
                    if (r.op == rcca_pkg::OP_INC_CK) begin
                        if (chunk_use[r.channel][r.chunk] == rcca_pkg::COUNT_MAX)
                            e.status = rcca_pkg::STAT_SATURATED;
                        else
                            chunk_use[r.channel][r.chunk]++;
                    end else if (r.op == rcca_pkg::OP_DEC_CK) begin
                        if (chunk_use[r.channel][r.chunk] == '0) begin
                            e.status = rcca_pkg::STAT_UNDERFLOW;
                        end else begin
                            chunk_use[r.channel][r.chunk]--;
                            if (chunk_use[r.channel][r.chunk] == '0) begin
                                e.freed = 1'b1;
                                eos_flag[r.channel][r.chunk] = 1'b0;
                            end
                        end
                    end else if (r.op == rcca_pkg::OP_SET_EOS) begin
                        eos_flag[r.channel][r.chunk] = r.eos_in;
                    end
                    e.count = chunk_use[r.channel][r.chunk];
                    e.eos_out = eos_flag[r.channel][r.chunk];
                end
            end
            default: ;
        endcase
        return e;
    endfunction

    task automatic report_mismatch(string field, int expected, int actual);
        $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, field, expected,
                 actual);
        error_count++;
    endtask

    // Called right after a rising edge; returns right after the accepting edge.
    task automatic send_request(rcca_pkg::req_t r);
        int gap;
        rcca_pkg::res_t want;
        gap = draw_wait(src_stretch, src_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, r};
        do @(posedge aclk); while (!s_tready);
        want = predict_pool_result(r);
        pending_results.insert(pending_results.size(), want);
    endtask

    always @(posedge aclk) begin
        rcca_pkg::res_t got;
        rcca_pkg::res_t want;
        if (m_tvalid && m_tready) begin
            got = rcca_pkg::res_t'(m_tdata[$bits(rcca_pkg::res_t)-1:0]);
            if (pending_results.size() == 0) begin
                $display("[%0t] result transfer with nothing outstanding: %h", $realtime,
                         m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.slot != want.slot)
                    report_mismatch("slot", want.slot, got.slot);
                if (got.count != want.count)
                    report_mismatch("count", want.count, got.count);
                if (got.eos_out != want.eos_out)
                    report_mismatch("eos_out", want.eos_out, got.eos_out);
                if (got.freed != want.freed)
                    report_mismatch("freed", want.freed, got.freed);
                if (got.status != want.status)
                    report_mismatch("status", want.status, got.status);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side back-pressure.
    initial begin
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = draw_wait(snk_stretch, snk_calm);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic test_directed_ops;
        send_request(make_req(rcca_pkg::OP_ALLOC_CH, 0, 0, 0, 1'b0));
        send_request(make_req(rcca_pkg::OP_READ_CH, 0, 0, 0, 1'b0));
        send_request(make_req(rcca_pkg::OP_INC_CH, 0, 0, 0, 1'b0));
        send_request(make_req(rcca_pkg::OP_SET_CH, 0, 0, 255, 1'b0));
        // Incrementing a full count must hold it and flag saturation.
        send_request(make_req(rcca_pkg::OP_INC_CH, 0, 0, 0, 1'b0));
        send_request(make_req(rcca_pkg::OP_SET_CH, 31, 31, 0, 1'b1));
        send_request(make_req(rcca_pkg::OP_DEC_CH, 31, 0, 0, 1'b0));
        send_request(make_req(rcca_pkg::OP_ALLOC_CK, 0, 17, 0, 1'b0));
        send_request(make_req(rcca_pkg::OP_SET_EOS, 0, 0, 0, 1'b1));
        send_request(make_req(rcca_pkg::OP_READ_EOS, 0, 0, 0, 1'b0));
        send_request(make_req(rcca_pkg::OP_INC_CK, 0, 0, 0, 1'b0));
        send_request(make_req(rcca_pkg::OP_DEC_CK, 0, 0, 0, 1'b0));
        // Dropping the last reference clears the end-of-stream flag.
        send_request(make_req(rcca_pkg::OP_DEC_CK, 0, 0, 0, 1'b0));
        send_request(make_req(rcca_pkg::OP_DEC_CK, 0, 0, 0, 1'b0));
        send_request(make_req(rcca_pkg::OP_READ_CK, 0, 31, 0, 1'b0));
        send_request(make_req(rcca_pkg::OP_INC_CK, 31, 31, 255, 1'b1));
        send_request(make_req(rcca_pkg::OP_SET_EOS, 31, 31, 255, 1'b1));
        send_request(make_req(rcca_pkg::OP_READ_CK, 31, 31, 0, 1'b0));
        send_request(make_req(rcca_pkg::op_t'(OP_UNUSED_FIRST), 31, 31, 255, 1'b1));
        send_request(make_req(rcca_pkg::op_t'(OP_UNUSED_LAST), 31, 31, 255, 1'b1));
        send_request(make_req(rcca_pkg::OP_ALLOC_CK, 0, 0, 0, 1'b0));
        send_request(make_req(rcca_pkg::OP_SET_CH, 0, 0, 1, 1'b0));
        send_request(make_req(rcca_pkg::OP_DEC_CH, 0, 0, 0, 1'b0));
        send_request(make_req(rcca_pkg::OP_READ_CK, 0, 0, 0, 1'b0));
        send_request(make_req(rcca_pkg::OP_READ_EOS, 31, 31, 0, 1'b0));
    endtask

    task automatic test_pool_exhaustion;
        for (int i = 0; i <= CH_SCAN; i++)
            send_request(make_req(rcca_pkg::OP_ALLOC_CH, 0, 0, 0, 1'b0));
        for (int i = 0; i <= CK_SCAN; i++)
            send_request(make_req(rcca_pkg::OP_ALLOC_CK, 2, 0, 0, 1'b0));
        send_request(make_req(rcca_pkg::OP_SET_EOS, 2, 31, 0, 1'b1));
        // Release the channel: the chunk row sweep frees every chunk.
        send_request(make_req(rcca_pkg::OP_SET_CH, 2, 0, 1, 1'b0));
        send_request(make_req(rcca_pkg::OP_DEC_CH, 2, 0, 0, 1'b0));
        send_request(make_req(rcca_pkg::OP_READ_EOS, 2, 31, 0, 1'b0));
        send_request(make_req(rcca_pkg::OP_ALLOC_CK, 2, 0, 0, 1'b0));
        send_request(make_req(rcca_pkg::OP_READ_CK, 2, 31, 0, 1'b0));
    endtask

    task automatic test_chunk_saturation;
        for (int i = 0; i < 257; i++)
            send_request(make_req(rcca_pkg::OP_INC_CK, 1, 3, 0, 1'b0));
        send_request(make_req(rcca_pkg::OP_DEC_CK, 1, 3, 0, 1'b0));
        send_request(make_req(rcca_pkg::OP_INC_CK, 1, 3, 0, 1'b0));
        send_request(make_req(rcca_pkg::OP_INC_CK, 1, 3, 0, 1'b0));
        send_request(make_req(rcca_pkg::OP_SET_CH, 1, 0, 254, 1'b0));
        send_request(make_req(rcca_pkg::OP_INC_CH, 1, 0, 0, 1'b0));
        send_request(make_req(rcca_pkg::OP_INC_CH, 1, 0, 0, 1'b0));
    endtask

    function automatic rcca_pkg::req_t random_request();
        rcca_pkg::req_t r;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            r.op = rcca_pkg::op_t'(4'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)));
        else if (pick < 10) r.op = rcca_pkg::OP_ALLOC_CH;
        else if (pick < 16) r.op = rcca_pkg::OP_INC_CH;
        else if (pick < 26) r.op = rcca_pkg::OP_DEC_CH;
        else if (pick < 32) r.op = rcca_pkg::OP_SET_CH;
        else if (pick < 36) r.op = rcca_pkg::OP_READ_CH;
        else if (pick < 52) r.op = rcca_pkg::OP_ALLOC_CK;
        else if (pick < 62) r.op = rcca_pkg::OP_INC_CK;
        else if (pick < 76) r.op = rcca_pkg::OP_DEC_CK;
        else if (pick < 82) r.op = rcca_pkg::OP_READ_CK;
        else if (pick < 92) r.op = rcca_pkg::OP_SET_EOS;
        else                r.op = rcca_pkg::OP_READ_EOS;
        // Most requests hit a few channels and chunks so that counts interact.
        r.channel = ($urandom_range(0, 4) != 0) ? rcca_pkg::IDX_W'($urandom_range(0, 3))
                                                : rcca_pkg::IDX_W'($urandom);
        r.chunk = ($urandom_range(0, 3) != 0) ? rcca_pkg::IDX_W'($urandom_range(0, 7))
                                              : rcca_pkg::IDX_W'($urandom);
        case ($urandom_range(0, 4))
            0:       r.new_count = '0;
            1:       r.new_count = rcca_pkg::CNT_W'(1);
            2:       r.new_count = rcca_pkg::CNT_W'(2);
            3:       r.new_count = rcca_pkg::COUNT_MAX;
            default: r.new_count = rcca_pkg::CNT_W'($urandom);
        endcase
        r.eos_in = 1'($urandom);
        return r;
    endfunction

    task automatic test_random_traffic;
        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_request(random_request());
    endtask

    initial begin
        for (int i = 0; i < CH_N; i++) begin
            channel_use[i] = '0;
            for (int j = 0; j < CK_N; j++) begin
                chunk_use[i][j] = '0;
                eos_flag[i][j] = 1'b0;
            end
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_ops();
        test_pool_exhaustion();
        test_chunk_saturation();
        test_random_traffic();
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
